FILE: design/mfw_pkg.sv
// Shared constants, types and codes for the median filter window unit.
// Used by every module of the block but mfw_checker; depends on nothing else.

package mfw_pkg;

    localparam int WINDOW_SIZE = 3;
    localparam int MAX_WIDTH   = 2048;

    localparam int HALF = WINDOW_SIZE / 2;
    localparam int SPAN = 2 * HALF + 1;
    localparam int TAPS = SPAN * SPAN;
    localparam int MID  = TAPS / 2;
    localparam int HIST = 2 * HALF;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CW1    = COL_W + 1;
    localparam int SLOT_W = $clog2(SPAN);
    localparam int FW_W   = 12;
    localparam int FH_W   = 13;
    localparam int ROW_W  = FH_W;
    localparam int THR_W  = CW1 + 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam int LAYERS_PER_STAGE = 3;
    localparam int SORT_STAGES = (TAPS + LAYERS_PER_STAGE - 1) / LAYERS_PER_STAGE;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    localparam logic OP_PIXEL = 1'b0;

    typedef logic [7:0] pixel_t;
    typedef logic [SPAN-1:0][7:0] col_t;
    typedef logic [TAPS-1:0][7:0] taps_t;

    // Line store access and result decision made when an item is taken.
    typedef struct packed {
        logic              we;
        logic              emit;
        logic              interior;
        logic              last;
        logic [SLOT_W-1:0] wslot;
        logic [SLOT_W-1:0] oslot;
        logic [COL_W-1:0]  icol;
        logic [COL_W-1:0]  ocol;
        pixel_t            pixel;
    } lsreq_t;

    // One result on its way through the window and sorting stages.
    typedef struct packed {
        logic   interior;
        logic   last;
        pixel_t copy;
        taps_t  taps;
    } item_t;

endpackage

FILE: design/mfw_ctrl.sv
// Frame position counters, configuration registers and result decision.
// Depends on mfw_pkg.

module mfw_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mfw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mfw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             opcode,
    input  mfw_pkg::pixel_t                  pixel,
    output mfw_pkg::lsreq_t                  req
);

    logic [mfw_pkg::FW_W-1:0]   width_reg, width_next;
    logic [mfw_pkg::FH_W-1:0]   height_reg, height_next;
    logic [mfw_pkg::ROW_W-1:0]  in_row_reg, in_row_next;
    logic [mfw_pkg::COL_W-1:0]  in_col_reg, in_col_next;
    logic [mfw_pkg::SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [mfw_pkg::ROW_W-1:0]  out_row_reg, out_row_next;
    logic [mfw_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [mfw_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [mfw_pkg::THR_W-1:0]  lead_reg, lead_next;

    logic [mfw_pkg::CW1-1:0]    w_eff;
    logic [mfw_pkg::ROW_W-1:0]  h_eff;
    logic [mfw_pkg::THR_W-1:0]  thr;
    logic accept, input_done, is_pixel, wr, emit;
    logic in_col_end, out_col_end, out_row_end, interior, last, restart;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = mfw_pkg::CW1'(1);
        else if (int'(width_reg) > mfw_pkg::MAX_WIDTH)
            w_eff = mfw_pkg::CW1'(mfw_pkg::MAX_WIDTH);
        else
            w_eff = mfw_pkg::CW1'(width_reg);
        h_eff = (height_reg == '0) ? mfw_pkg::ROW_W'(1) : height_reg;
    end

    // Number of pixels that must arrive before the first result of a frame.
    assign thr = mfw_pkg::THR_W'(w_eff) * mfw_pkg::THR_W'(mfw_pkg::HALF)
               + mfw_pkg::THR_W'(mfw_pkg::HALF);

    assign accept     = in_valid && in_ready;
    assign input_done = in_row_reg >= h_eff;
    assign is_pixel   = opcode == mfw_pkg::OP_PIXEL;
    assign wr         = accept && !input_done && is_pixel;
    assign emit       = accept && (input_done || (is_pixel && lead_reg == thr));

    assign in_col_end  = (mfw_pkg::CW1'(in_col_reg) + mfw_pkg::CW1'(1)) >= w_eff;
    assign out_col_end = (mfw_pkg::CW1'(out_col_reg) + mfw_pkg::CW1'(1)) >= w_eff;
    assign out_row_end = (mfw_pkg::ROW_W'(out_row_reg + mfw_pkg::ROW_W'(1))) == h_eff;
    assign last        = out_row_end && out_col_end;

    assign interior =
        (out_row_reg >= mfw_pkg::ROW_W'(mfw_pkg::HALF)) &&
        ((mfw_pkg::ROW_W+1)'(out_row_reg) + (mfw_pkg::ROW_W+1)'(mfw_pkg::HALF)
            < (mfw_pkg::ROW_W+1)'(h_eff)) &&
        (out_col_reg >= mfw_pkg::COL_W'(mfw_pkg::HALF)) &&
        ((mfw_pkg::CW1+1)'(out_col_reg) + (mfw_pkg::CW1+1)'(mfw_pkg::HALF)
            < (mfw_pkg::CW1+1)'(w_eff));

    always_comb
    begin
        width_next    = width_reg;
        height_next   = height_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        lead_next     = lead_reg;
        restart       = 1'b0;

        if (cfg_we)
        begin
            unique case (mfw_pkg::cfg_index_t'(cfg_index))
                mfw_pkg::CFG_FRAME_WIDTH:  width_next  = cfg_data[mfw_pkg::FW_W-1:0];
                mfw_pkg::CFG_FRAME_HEIGHT: height_next = cfg_data[mfw_pkg::FH_W-1:0];
            endcase
            restart = 1'b1;
        end
        else
        begin
            if (wr)
            begin
                if (in_col_end)
                begin
                    in_col_next  = '0;
                    in_row_next  = in_row_reg + mfw_pkg::ROW_W'(1);
                    in_slot_next = (in_slot_reg == mfw_pkg::SLOT_W'(mfw_pkg::SPAN - 1)) ?
                                   '0 : in_slot_reg + mfw_pkg::SLOT_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + mfw_pkg::COL_W'(1);
                end
                if (lead_reg < thr)
                    lead_next = lead_reg + mfw_pkg::THR_W'(1);
            end
            if (emit)
            begin
                if (last)
                begin
                    restart = 1'b1;
                end
                else if (out_col_end)
                begin
                    out_col_next  = '0;
                    out_row_next  = out_row_reg + mfw_pkg::ROW_W'(1);
                    out_slot_next = (out_slot_reg == mfw_pkg::SLOT_W'(mfw_pkg::SPAN - 1)) ?
                                    '0 : out_slot_reg + mfw_pkg::SLOT_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + mfw_pkg::COL_W'(1);
                end
            end
        end

        if (restart)
        begin
            in_row_next   = '0;
            in_col_next   = '0;
            in_slot_next  = '0;
            out_row_next  = '0;
            out_col_next  = '0;
            out_slot_next = '0;
            lead_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= mfw_pkg::FW_W'(512);
            height_reg   <= mfw_pkg::FH_W'(512);
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            lead_reg     <= '0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            lead_reg     <= lead_next;
        end
    end

    always_comb
    begin
        req.we       = wr;
        req.emit     = emit;
        req.interior = interior;
        req.last     = last;
        req.wslot    = in_slot_reg;
        req.oslot    = out_slot_reg;
        req.icol     = in_col_reg;
        req.ocol     = out_col_reg;
        req.pixel    = pixel;
    end

endmodule

FILE: design/mfw_window.sv
// Line store banks, column read stage and sliding window assembly.
// Depends on mfw_pkg; fed by mfw_ctrl, feeds mfw_sorter.

module mfw_window (
    input  logic              clk,
    input  logic              rst_n,
    input  mfw_pkg::lsreq_t   req,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output mfw_pkg::item_t    out_item
);

    mfw_pkg::pixel_t rd_a_reg [mfw_pkg::SPAN];
    mfw_pkg::pixel_t rd_b_reg [mfw_pkg::SPAN];
    logic            v1_reg;
    mfw_pkg::lsreq_t m1_reg;
    logic            v2_reg;
    mfw_pkg::item_t  item2_reg, item2_next;
    mfw_pkg::col_t [mfw_pkg::HIST-1:0] hist_reg;

    mfw_pkg::col_t   col_now;
    logic            ready1, ready2, xfer12;

    // One bank per row slot. Port A reads the newest column of the window,
    // port B reads the pixel that a border position copies through.
    for (genvar b = 0; b < mfw_pkg::SPAN; b++)
    begin : g_bank
        mfw_pkg::pixel_t bank_mem [mfw_pkg::MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (req.we && req.wslot == mfw_pkg::SLOT_W'(b))
                bank_mem[req.icol] <= req.pixel;
            if (req.emit)
            begin
                rd_a_reg[b] <= bank_mem[req.icol];
                rd_b_reg[b] <= bank_mem[req.ocol];
            end
        end
    end

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;
    assign xfer12   = v1_reg && ready2;

    // The pixel written in the same transaction is the newest one in its
    // column, so it replaces the stale read of its own bank.
    always_comb
    begin
        for (int b = 0; b < mfw_pkg::SPAN; b++)
            col_now[b] = (m1_reg.we && m1_reg.wslot == mfw_pkg::SLOT_W'(b)) ?
                         m1_reg.pixel : rd_a_reg[b];

        item2_next.interior = m1_reg.interior;
        item2_next.last     = m1_reg.last;
        item2_next.copy     = rd_b_reg[m1_reg.oslot];
        for (int b = 0; b < mfw_pkg::SPAN; b++)
            item2_next.taps[b] = col_now[b];
        for (int j = 1; j < mfw_pkg::SPAN; j++)
            for (int b = 0; b < mfw_pkg::SPAN; b++)
                item2_next.taps[j * mfw_pkg::SPAN + b] = hist_reg[j - 1][b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= req.emit;
            if (ready2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.emit)
            m1_reg <= req;
        if (xfer12)
        begin
            hist_reg  <= {hist_reg[mfw_pkg::HIST-2:0], col_now};
            item2_reg <= item2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;

endmodule

FILE: design/mfw_sorter.sv
// Pipelined odd-even transposition sort of the window and result register.
// Depends on mfw_pkg; fed by mfw_window.

module mfw_sorter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mfw_pkg::item_t    in_item,
    output logic              m_valid,
    input  logic              m_ready,
    output mfw_pkg::pixel_t   m_pixel,
    output logic              m_last
);

    mfw_pkg::item_t  st_reg [mfw_pkg::SORT_STAGES];
    logic            sv_reg [mfw_pkg::SORT_STAGES];
    logic            out_v_reg;
    mfw_pkg::pixel_t out_pix_reg;
    logic            out_last_reg;
    logic [mfw_pkg::SORT_STAGES:0] rdy;

    function automatic mfw_pkg::taps_t sort_layers(mfw_pkg::taps_t t, int first);
        mfw_pkg::pixel_t lo;
        mfw_pkg::pixel_t hi;
        for (int l = 0; l < mfw_pkg::LAYERS_PER_STAGE; l++)
            for (int j = 0; j < mfw_pkg::TAPS - 1; j++)
                if (((j + first + l) & 1) == 0)
                begin
                    lo = (t[j] > t[j + 1]) ? t[j + 1] : t[j];
                    hi = (t[j] > t[j + 1]) ? t[j] : t[j + 1];
                    t[j]     = lo;
                    t[j + 1] = hi;
                end
        return t;
    endfunction

    always_comb
    begin
        rdy[mfw_pkg::SORT_STAGES] = !out_v_reg || m_ready;
        for (int s = mfw_pkg::SORT_STAGES - 1; s >= 0; s--)
            rdy[s] = !sv_reg[s] || rdy[s + 1];
    end

    assign in_ready = rdy[0];

    for (genvar s = 0; s < mfw_pkg::SORT_STAGES; s++)
    begin : g_stage
        mfw_pkg::item_t src;
        mfw_pkg::item_t dst;
        logic           src_v;

        if (s == 0)
        begin : g_first
            assign src   = in_item;
            assign src_v = in_valid;
        end
        else
        begin : g_rest
            assign src   = st_reg[s - 1];
            assign src_v = sv_reg[s - 1];
        end

        always_comb
        begin
            dst      = src;
            dst.taps = sort_layers(src.taps, s * mfw_pkg::LAYERS_PER_STAGE);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[s] <= 1'b0;
            else if (rdy[s])
                sv_reg[s] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && src_v)
                st_reg[s] <= dst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (rdy[mfw_pkg::SORT_STAGES])
            out_v_reg <= sv_reg[mfw_pkg::SORT_STAGES - 1];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[mfw_pkg::SORT_STAGES] && sv_reg[mfw_pkg::SORT_STAGES - 1])
        begin
            out_pix_reg  <= st_reg[mfw_pkg::SORT_STAGES - 1].interior ?
                            st_reg[mfw_pkg::SORT_STAGES - 1].taps[mfw_pkg::MID] :
                            st_reg[mfw_pkg::SORT_STAGES - 1].copy;
            out_last_reg <= st_reg[mfw_pkg::SORT_STAGES - 1].last;
        end
    end

    assign m_valid = out_v_reg;
    assign m_pixel = out_pix_reg;
    assign m_last  = out_last_reg;

endmodule

FILE: design/median_filter_window_unit.sv
// After the transaction that causes it, a result passes the line store read,
// window assembly, three sorting stages of three compare layers each, and
// the output register, each of them a register stage.
// Throughput: one transaction per clock on both sides; stalls hold every stage.
// Reset sets a 512 x 512 frame and clears all counters and valid bits; the
// line store is not cleared, since only pixels of the current frame are read.

module median_filter_window_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] pixel_in
    input  logic                            s_tuser,  // [0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,  // [7:0] pixel_out
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [mfw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mfw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mfw_pkg::lsreq_t req;
    mfw_pkg::item_t  win_item;
    logic            win_valid;
    logic            sort_ready;

    mfw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .opcode    (s_tuser),
        .pixel     (s_tdata),
        .req       (req)
    );

    mfw_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .in_ready  (s_tready),
        .out_valid (win_valid),
        .out_ready (sort_ready),
        .out_item  (win_item)
    );

    mfw_sorter u_sorter (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (win_valid),
        .in_ready (sort_ready),
        .in_item  (win_item),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_pixel  (m_tdata),
        .m_last   (m_tlast)
    );

endmodule

FILE: design/mfw_checker.sv
// Port-level checks for median_filter_window_unit, attached with bind.
// Depends only on the port list of the top level.

module mfw_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,
    input  logic                            m_tlast
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // With the sink ready every stage can move, so the source side must be open.
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input blocked while output side is ready");

    // Nothing comes out right after reset is released.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid straight out of reset");

endmodule

bind median_filter_window_unit mfw_checker u_mfw_checker (.*);

FILE: verif/median_filter_window_unit_checker.sv
// Passive checker for the median filter window unit: follows the pixel, result and
// register channels, predicts every filtered pixel and compares it on arrival.
// Depends on mfw_pkg for the window geometry, register indexes and pixel type.

module median_filter_window_unit_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] pixel_in
    input  logic                            s_tuser,  // [0] opcode
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,  // [7:0] pixel_out
    input  logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [mfw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mfw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatch_count,
    output int                              results_owed
);

    typedef struct packed {
        mfw_pkg::pixel_t pixel;
        logic            frame_end;
    } filtered_px_t;

    logic [mfw_pkg::FW_W-1:0] frame_width;
    logic [mfw_pkg::FH_W-1:0] frame_height;
    mfw_pkg::pixel_t          row_hist [mfw_pkg::SPAN][mfw_pkg::MAX_WIDTH];
    int unsigned              in_row;
    int unsigned              in_col;
    int unsigned              out_row;
    int unsigned              out_col;
    int unsigned              results_seen;
    filtered_px_t             filtered_q [$];

    task automatic rewind();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endtask

    function automatic mfw_pkg::pixel_t median_of(input mfw_pkg::taps_t win);
        mfw_pkg::pixel_t hold;
        int              i;
        int              j;
        for (i = 0; i < mfw_pkg::TAPS - 1; i++)
            for (j = 0; j < mfw_pkg::TAPS - 1 - i; j++)
                if (win[j] > win[j+1])
                begin
                    hold     = win[j];
                    win[j]   = win[j+1];
                    win[j+1] = hold;
                end
        return win[mfw_pkg::MID];
    endfunction

    // Filtered value for the next output position, then step that position on.
    task automatic emit_filtered(input int unsigned w, input int unsigned h);
        mfw_pkg::taps_t win;
        filtered_px_t   res;
        int unsigned    n;
        int unsigned    dr;
        int unsigned    dc;
        n = 0;
        if (out_row >= mfw_pkg::HALF && out_row + mfw_pkg::HALF < h &&
            out_col >= mfw_pkg::HALF && out_col + mfw_pkg::HALF < w)
        begin
            for (dr = 0; dr < mfw_pkg::SPAN; dr++)
                for (dc = 0; dc < mfw_pkg::SPAN; dc++)
                begin
                    win[n] = row_hist[(out_row - mfw_pkg::HALF + dr) % mfw_pkg::SPAN]
                                     [(out_col - mfw_pkg::HALF + dc) % mfw_pkg::MAX_WIDTH];
                    n++;
                end
            res.pixel = median_of(win);
        end
        else
        begin
            res.pixel = row_hist[out_row % mfw_pkg::SPAN][out_col % mfw_pkg::MAX_WIDTH];
        end
        res.frame_end = (out_row + 1 == h && out_col + 1 == w);
        filtered_q.insert(filtered_q.size(), res);
        if (res.frame_end)
        begin
            rewind();
        end
        else if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row = out_row + 1;
        end
        else
        begin
            out_col = out_col + 1;
        end
    endtask

    task automatic take_item(input logic opcode, input mfw_pkg::pixel_t pix);
        int unsigned w;
        int unsigned h;
        int unsigned k;
        w = (frame_width == 0) ? 1 : frame_width;
        if (w > mfw_pkg::MAX_WIDTH)
            w = mfw_pkg::MAX_WIDTH;
        h = (frame_height == 0) ? 1 : frame_height;
        // Once the whole frame is in, every transaction drains one result.
        if (in_row >= h)
        begin
            emit_filtered(w, h);
        end
        else if (opcode == mfw_pkg::OP_PIXEL)
        begin
            row_hist[in_row % mfw_pkg::SPAN][in_col % mfw_pkg::MAX_WIDTH] = pix;
            k = in_row * w + in_col;
            if (in_col + 1 >= w)
            begin
                in_col = 0;
                in_row = in_row + 1;
            end
            else
            begin
                in_col = in_col + 1;
            end
            if (k >= mfw_pkg::HALF * w + mfw_pkg::HALF)
                emit_filtered(w, h);
        end
    endtask

    task automatic check_result(input mfw_pkg::pixel_t pix, input logic fe);
        filtered_px_t want;
        if (filtered_q.size() == 0)
        begin
            if (mismatch_count < 10)
                $display("[%0t] result %0d arrived with none expected: pixel %0d frame_end %0b",
                         $time, results_seen, pix, fe);
            mismatch_count++;
        end
        else
        begin
            want = filtered_q.pop_front();
            if (pix !== want.pixel || fe !== want.frame_end)
            begin
                if (mismatch_count < 10)
                    $display({"[%0t] result %0d: expected pixel %0d frame_end %0b, ",
                              "got pixel %0d frame_end %0b"},
                             $time, results_seen, want.pixel, want.frame_end, pix, fe);
                mismatch_count++;
            end
        end
        results_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Power-on geometry is a 512 x 512 frame.
            frame_width    = mfw_pkg::FW_W'(512);
            frame_height   = mfw_pkg::FH_W'(512);
            mismatch_count = 0;
            results_seen   = 0;
            rewind();
            filtered_q.delete();
            results_owed <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tlast);
            if (cfg_we)
            begin
                case (cfg_index)
                    mfw_pkg::CFG_FRAME_WIDTH:
                    begin
                        frame_width = cfg_data[mfw_pkg::FW_W-1:0];
                        rewind();
                    end
                    mfw_pkg::CFG_FRAME_HEIGHT:
                    begin
                        frame_height = cfg_data[mfw_pkg::FH_W-1:0];
                        rewind();
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_item(s_tuser, s_tdata);
            results_owed <= filtered_q.size();
        end
    end

endmodule

FILE: verif/median_filter_window_unit_test.sv
// Testbench top for the median filter window unit: clock, reset, frame stimulus with
// random idling on both channels, and the verdict. Needs mfw_pkg, the block and
// median_filter_window_unit_checker, which does all prediction and comparison.

module median_filter_window_unit_test;

    localparam int   LATENCY      = mfw_pkg::SORT_STAGES + 3;
    localparam int   SETTLE       = LATENCY + 6;
    localparam int   STALL_LIMIT  = 1000;
    localparam int   TARGET_ITEMS = 500;
    localparam logic OP_FLUSH     = ~mfw_pkg::OP_PIXEL;

    typedef enum {
        TEX_UNIFORM,
        TEX_SALT_PEPPER,
        TEX_FLAT
    } texture_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [7:0]                     m_tdata;
    logic                           m_tlast;
    logic                           cfg_we;
    logic [mfw_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mfw_pkg::CFG_DATA_W-1:0] cfg_data;

    int          mismatch_count;
    int          results_owed;
    int unsigned eff_w;
    int unsigned eff_h;
    int          items_sent;
    int          idle_cycles;
    bit          src_calm;

    median_filter_window_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    median_filter_window_unit_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic mfw_pkg::pixel_t noise_byte();
        return mfw_pkg::pixel_t'($urandom_range(0, 255));
    endfunction

    function automatic mfw_pkg::pixel_t draw_pixel(input texture_t tex);
        mfw_pkg::pixel_t pix;
        case (tex)
            TEX_SALT_PEPPER:
                if ($urandom_range(0, 3) == 0)
                    pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else
                    pix = mfw_pkg::pixel_t'($urandom_range(100, 120));
            TEX_FLAT:
                pix = mfw_pkg::pixel_t'($urandom_range(127, 129));
            default:
                pix = noise_byte();
        endcase
        return pix;
    endfunction

    task automatic send_item(input logic op, input mfw_pkg::pixel_t pix);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= pix;
        do @(posedge clk); while (s_tready !== 1'b1);
    endtask

    // Waits until every predicted result has left, then for the pipeline to empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [mfw_pkg::FW_W-1:0] w_raw,
                                input logic [mfw_pkg::FH_W-1:0] h_raw);
        bit spare;
        spare = 1'($urandom_range(0, 1));
        cfg_we    <= 1'b1;
        cfg_index <= mfw_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= {spare, w_raw};
        @(posedge clk);
        cfg_index <= mfw_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= h_raw;
        @(posedge clk);
        cfg_we <= 1'b0;
        eff_w = (w_raw == 0) ? 1 : w_raw;
        if (eff_w > mfw_pkg::MAX_WIDTH)
            eff_w = mfw_pkg::MAX_WIDTH;
        eff_h = (h_raw == 0) ? 1 : h_raw;
    endtask

    // One frame of pixels. A nonzero stop_after under total abandons it after that many
    // pixels; otherwise the tail is pushed out by flush ticks and dropped pixels.
    task automatic run_frame(input texture_t tex, input int unsigned stop_after);
        int unsigned total;
        int unsigned pixels;
        int unsigned tail;
        int unsigned n;
        total  = eff_w * eff_h;
        pixels = (stop_after == 0 || stop_after >= total) ? total : stop_after;
        for (n = 0; n < pixels; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(OP_FLUSH, noise_byte());
            send_item(mfw_pkg::OP_PIXEL, draw_pixel(tex));
            items_sent++;
        end
        if (pixels == total)
        begin
            tail = mfw_pkg::HALF * eff_w + mfw_pkg::HALF;
            if (tail > total)
                tail = total;
            for (n = 0; n < tail; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(mfw_pkg::OP_PIXEL, noise_byte());
                else
                    send_item(OP_FLUSH, noise_byte());
                items_sent++;
            end
            if ($urandom_range(0, 4) == 0)
                send_item(OP_FLUSH, noise_byte());
        end
    endtask

    initial
    begin : sink
        int stall;
        bit sink_calm;
        sink_calm = 1'b0;
        m_tready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("median_filter_window_unit_test: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [mfw_pkg::FW_W-1:0] w_raw;
        logic [mfw_pkg::FH_W-1:0] h_raw;
        int unsigned              total;
        int unsigned              stop_after;
        int                       frames;
        mfw_pkg::pixel_t          cross_px [9];
        int                       n;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = mfw_pkg::OP_PIXEL;
        cfg_we      = 1'b0;
        cfg_index   = mfw_pkg::CFG_FRAME_WIDTH;
        cfg_data    = '0;
        items_sent  = 0;
        src_calm    = 1'b0;
        eff_w       = 512;
        eff_h       = 512;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Power-on geometry: start a frame well short of its first result,
        // then drop it with a register write.
        run_frame(TEX_UNIFORM, 40);
        settle();

        // 3 x 3 frame with a single interior pixel whose window mixes both extremes.
        set_geometry(12'd3, 13'd3);
        cross_px = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h00, 8'hFF};
        for (n = 0; n < 9; n++)
        begin
            if (n == 5)
                send_item(OP_FLUSH, 8'hFF);
            send_item(mfw_pkg::OP_PIXEL, cross_px[n]);
        end
        send_item(OP_FLUSH, 8'h00);
        send_item(mfw_pkg::OP_PIXEL, 8'hFF);
        send_item(OP_FLUSH, 8'hFF);
        send_item(OP_FLUSH, 8'h00);
        settle();

        // Too narrow for any interior pixel, then zero width and height.
        set_geometry(12'd2, 13'd2);
        run_frame(TEX_SALT_PEPPER, 0);
        settle();
        set_geometry(12'd0, 13'd0);
        run_frame(TEX_UNIFORM, 0);
        settle();

        // Largest geometries, each started and then dropped: clamped width,
        // tall single column, height above 4096.
        set_geometry(12'd4095, 13'd0);
        run_frame(TEX_SALT_PEPPER, 40);
        settle();
        set_geometry(12'd1, 13'd4097);
        run_frame(TEX_UNIFORM, 40);
        settle();
        set_geometry(12'd7, 13'd8191);
        run_frame(TEX_UNIFORM, 60);
        settle();

        while (items_sent < TARGET_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                w_raw = mfw_pkg::FW_W'($urandom_range(0, 2));
            else
                w_raw = mfw_pkg::FW_W'($urandom_range(3, 12));
            h_raw = ($urandom_range(0, 7) == 0) ? '0 : mfw_pkg::FH_W'($urandom_range(1, 9));
            if ($urandom_range(0, 9) == 0)
            begin
                w_raw = mfw_pkg::FW_W'($urandom_range(13, 40));
                h_raw = mfw_pkg::FH_W'($urandom_range(1, 3));
            end
            set_geometry(w_raw, h_raw);
            frames = $urandom_range(1, 2);
            repeat (frames)
            begin
                if (items_sent < TARGET_ITEMS)
                begin
                    src_calm   = ($urandom_range(0, 3) == 0);
                    total      = eff_w * eff_h;
                    stop_after = 0;
                    if (total > 1 && $urandom_range(0, 4) == 0)
                        stop_after = $urandom_range(1, total - 1);
                    run_frame(texture_t'($urandom_range(0, 2)), stop_after);
                end
            end
            settle();
        end

        if (mismatch_count == 0 && results_owed == 0)
            $display("median_filter_window_unit_test: PASS");
        else
            $display("median_filter_window_unit_test: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/mfw_pkg.sv
design/mfw_ctrl.sv
design/mfw_window.sv
design/mfw_sorter.sv
design/median_filter_window_unit.sv
design/mfw_checker.sv
verif/median_filter_window_unit_checker.sv
verif/median_filter_window_unit_test.sv
